FILE: design/echo_range_binned_statistics_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the echo range binned statistics block
// Shorthand for clocked, reset-qualified implications.
// ----------------------------------------------------------------------------
`ifndef ECHO_RANGE_BINNED_STATISTICS_TOP_ASSERT_SVH
`define ECHO_RANGE_BINNED_STATISTICS_TOP_ASSERT_SVH

// Same-cycle implication
`define ERBS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("erbs: same-cycle check failed");

// Next-cycle implication
`define ERBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("erbs: next-cycle check failed");

`endif

FILE: design/erbs_pkg.sv
// ----------------------------------------------------------------------------
// erbs_pkg
// Types, constants and codes shared by the echo range binned statistics block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package erbs_pkg;

  localparam int BIN_COUNT       = 501;
  localparam int BIN_LAST        = BIN_COUNT - 1;
  localparam int BIN_W           = $clog2(BIN_COUNT);
  localparam int ECHOES_PER_SLOT = 3;
  localparam int ECHO_MAX        = 3;

  localparam int SLOT_W   = 10;
  localparam int DATA_W   = 16;
  localparam int RBIN_W   = 9;
  localparam int SUM_W    = 48;
  localparam int SQSUM_W  = 63;
  localparam int CNT_W    = 32;
  localparam int CFG_IDX_W = 3;

  // Divide by CM_PER_BIN as multiply by a reciprocal: exact for 16-bit inputs
  localparam int CM_PER_BIN  = 100;
  localparam int DIV_SHIFT   = 24;
  localparam int DIV_RECIP_W = 18;
  localparam logic [DIV_RECIP_W-1:0] DIV_RECIP =
    DIV_RECIP_W'(((1 << DIV_SHIFT) + CM_PER_BIN - 1) / CM_PER_BIN);
  localparam int QUOT_W = 10;

  localparam logic [SLOT_W-1:0] RST_SKIP_FIRST = 10'd296;
  localparam logic [SLOT_W-1:0] RST_SKIP_LAST  = 10'd325;
  localparam logic [DATA_W-1:0] RST_LIMIT      = 16'd65533;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SKIP_FIRST = 3'd0,
    CFG_SKIP_LAST  = 3'd1,
    CFG_DIST_LIMIT = 3'd2,
    CFG_PEAK_LIMIT = 3'd3,
    CFG_AREA_LIMIT = 3'd4
  } erbs_cfg_idx_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SEL,
    S_RD,
    S_MOD
  } erbs_state_e;

  typedef struct packed {
    logic [SLOT_W-1:0] skip_first;
    logic [SLOT_W-1:0] skip_last;
    logic [DATA_W-1:0] dist_limit;
    logic [DATA_W-1:0] peak_limit;
    logic [DATA_W-1:0] area_limit;
  } erbs_cfg_t;

  typedef struct packed {
    logic [DATA_W-1:0] distance;
    logic [DATA_W-1:0] peak;
    logic [DATA_W-1:0] area;
  } erbs_echo_t;

  typedef struct packed {
    logic                       mode;
    logic [SLOT_W-1:0]          slot;
    erbs_echo_t [ECHO_MAX-1:0]  echo;
    logic [RBIN_W-1:0]          read_bin;
  } erbs_item_t;

  typedef struct packed {
    logic             found;
    logic             rd_mode;
    erbs_echo_t       best;
    logic [BIN_W-1:0] bin;
  } erbs_pick_t;

  typedef struct packed {
    logic [SUM_W-1:0]   distance;
    logic [SUM_W-1:0]   area;
    logic [SUM_W-1:0]   peak;
    logic [SQSUM_W-1:0] area_sq;
    logic [SQSUM_W-1:0] peak_sq;
    logic [CNT_W-1:0]   count;
  } erbs_bin_t;

  typedef struct packed {
    logic              counted;
    logic [RBIN_W-1:0] bin_touched;
    erbs_bin_t         totals;
  } erbs_result_t;

endpackage

FILE: design/erbs_in_if.sv
// ----------------------------------------------------------------------------
// erbs_in_if
// Input channel: accumulate or read item with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface erbs_in_if;
  import erbs_pkg::*;

  logic              valid;
  logic              ready;
  logic              mode;
  logic [SLOT_W-1:0] slot_index;
  logic [DATA_W-1:0] first_distance;
  logic [DATA_W-1:0] first_peak;
  logic [DATA_W-1:0] first_area;
  logic [DATA_W-1:0] second_distance;
  logic [DATA_W-1:0] second_peak;
  logic [DATA_W-1:0] second_area;
  logic [DATA_W-1:0] third_distance;
  logic [DATA_W-1:0] third_peak;
  logic [DATA_W-1:0] third_area;
  logic [RBIN_W-1:0] read_bin;

  modport source (
    output valid, mode, slot_index, first_distance, first_peak, first_area,
           second_distance, second_peak, second_area, third_distance, third_peak,
           third_area, read_bin,
    input  ready
  );

  modport sink (
    input  valid, mode, slot_index, first_distance, first_peak, first_area,
           second_distance, second_peak, second_area, third_distance, third_peak,
           third_area, read_bin,
    output ready
  );
endinterface

FILE: design/erbs_out_if.sv
// ----------------------------------------------------------------------------
// erbs_out_if
// Result channel: one bin's totals per item, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface erbs_out_if;
  import erbs_pkg::*;

  logic               valid;
  logic               ready;
  logic               counted;
  logic [RBIN_W-1:0]  bin_touched;
  logic [SUM_W-1:0]   distance_total;
  logic [SUM_W-1:0]   area_total;
  logic [SUM_W-1:0]   peak_total;
  logic [SQSUM_W-1:0] area_square_total;
  logic [SQSUM_W-1:0] peak_square_total;
  logic [CNT_W-1:0]   sample_count;

  modport source (
    output valid, counted, bin_touched, distance_total, area_total, peak_total,
           area_square_total, peak_square_total, sample_count,
    input  ready
  );

  modport sink (
    input  valid, counted, bin_touched, distance_total, area_total, peak_total,
           area_square_total, peak_square_total, sample_count,
    output ready
  );
endinterface

FILE: design/erbs_cfg_if.sv
// ----------------------------------------------------------------------------
// erbs_cfg_if
// Configuration write channel: register index and data, valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface erbs_cfg_if;
  import erbs_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/erbs_select.sv
// ----------------------------------------------------------------------------
// erbs_select
// Echo qualification, strongest-echo pick and range-to-bin mapping.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module erbs_select (
  input  erbs_pkg::erbs_item_t item_i,
  input  erbs_pkg::erbs_cfg_t  cfg_i,
  output erbs_pkg::erbs_pick_t pick_o
);
  import erbs_pkg::*;

  always_comb begin
    logic                            found;
    logic                            ok;
    logic                            in_skip;
    erbs_echo_t                      best;
    logic [DATA_W+DIV_RECIP_W-1:0]   prod;
    logic [QUOT_W-1:0]               quot;
    logic [BIN_W-1:0]                acc_bin;
    logic [BIN_W-1:0]                rd_bin;

    found = 1'b0;
    best  = '0;
    for (int e = 0; e < ECHOES_PER_SLOT; e++) begin
      ok = (item_i.echo[e].distance != '0) &&
           (item_i.echo[e].distance <= cfg_i.dist_limit) &&
           (item_i.echo[e].peak != '0) && (item_i.echo[e].peak <= cfg_i.peak_limit) &&
           (item_i.echo[e].area != '0) && (item_i.echo[e].area <= cfg_i.area_limit);
      // strict compare keeps the earliest echo on a tie
      if (ok && (!found || (item_i.echo[e].peak > best.peak))) begin
        found = 1'b1;
        best  = item_i.echo[e];
      end
    end

    // an inverted range skips nothing
    in_skip = (item_i.slot >= cfg_i.skip_first) && (item_i.slot <= cfg_i.skip_last);

    prod = (DATA_W+DIV_RECIP_W)'(best.distance) * (DATA_W+DIV_RECIP_W)'(DIV_RECIP);
    quot = prod[DIV_SHIFT +: QUOT_W];

    if (DATA_W'(quot) > DATA_W'(BIN_LAST)) begin
      acc_bin = BIN_W'(BIN_LAST);
    end else begin
      acc_bin = BIN_W'(quot);
    end

    if (DATA_W'(item_i.read_bin) > DATA_W'(BIN_LAST)) begin
      rd_bin = BIN_W'(BIN_LAST);
    end else begin
      rd_bin = BIN_W'(item_i.read_bin);
    end

    pick_o.rd_mode = item_i.mode;
    pick_o.found   = found && !item_i.mode && !in_skip;
    pick_o.best    = best;
    pick_o.bin     = item_i.mode ? rd_bin : acc_bin;
  end

endmodule

FILE: design/echo_range_binned_statistics_top.sv
// ----------------------------------------------------------------------------
// echo_range_binned_statistics_top
// Per-bin lidar echo statistics held in one read-modify-write memory.
// ----------------------------------------------------------------------------
// Usage:
//   in_i   carries one item: mode 0 adds a slot's strongest valid echo,
//          mode 1 reads the totals of read_bin (clamped to the last bin).
//   out_o  returns exactly one result item per input item, in order.
//   cfg_i  writes the skip range and limits; always ready, index beyond the
//          register list is dropped. Write only while the block is idle.
// Sequence:
//   An accepted item runs through accept, echo pick and bin mapping,
//   memory read, and saturating update with write back, one step after
//   another. A new item is taken only once the last one has left the
//   update step, so items never overlap in the memory.
// Reset:
//   After rst_ni releases, a clearing pass zeroes the 501 bins, one per
//   cycle; in_i stays not ready until the pass is done.
// Stall:
//   A result waits in the output register; the next item is still accepted
//   and processed, and its write back holds until that result is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module echo_range_binned_statistics_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  erbs_in_if.sink      in_i,
  erbs_out_if.source   out_o,
  erbs_cfg_if.sink     cfg_i
);
  import erbs_pkg::*;

  `include "echo_range_binned_statistics_top_assert.svh"

  erbs_state_e         state_q, state_d;
  logic [BIN_W-1:0]    clr_cnt_q, clr_cnt_d;
  erbs_cfg_t           cfg_q;
  erbs_item_t          item_q;
  erbs_item_t          item_in;
  erbs_pick_t          pick_comb;
  erbs_pick_t          pick_q;
  logic [2*DATA_W-1:0] sq_area_q;
  logic [2*DATA_W-1:0] sq_peak_q;
  logic                out_valid_q;
  erbs_result_t        out_q;
  erbs_result_t        out_d;
  logic                out_free;
  logic                out_load;
  logic                in_accept;

  // bin memory, one entry holds the five sums and the sample count of a bin
  erbs_bin_t           bin_mem [BIN_COUNT];
  erbs_bin_t           mem_rdata_q;
  erbs_bin_t           mem_wdata;
  erbs_bin_t           upd;
  logic                mem_we;
  logic                mem_re;
  logic [BIN_W-1:0]    mem_waddr;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.skip_first <= RST_SKIP_FIRST;
      cfg_q.skip_last  <= RST_SKIP_LAST;
      cfg_q.dist_limit <= RST_LIMIT;
      cfg_q.peak_limit <= RST_LIMIT;
      cfg_q.area_limit <= RST_LIMIT;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_SKIP_FIRST: cfg_q.skip_first <= cfg_i.data[SLOT_W-1:0];
        CFG_SKIP_LAST:  cfg_q.skip_last  <= cfg_i.data[SLOT_W-1:0];
        CFG_DIST_LIMIT: cfg_q.dist_limit <= cfg_i.data;
        CFG_PEAK_LIMIT: cfg_q.peak_limit <= cfg_i.data;
        CFG_AREA_LIMIT: cfg_q.area_limit <= cfg_i.data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input capture
  // --------------------------------------------------------------------------
  always_comb begin
    item_in.mode              = in_i.mode;
    item_in.slot              = in_i.slot_index;
    item_in.echo[0].distance  = in_i.first_distance;
    item_in.echo[0].peak      = in_i.first_peak;
    item_in.echo[0].area      = in_i.first_area;
    item_in.echo[1].distance  = in_i.second_distance;
    item_in.echo[1].peak      = in_i.second_peak;
    item_in.echo[1].area      = in_i.second_area;
    item_in.echo[2].distance  = in_i.third_distance;
    item_in.echo[2].peak      = in_i.third_peak;
    item_in.echo[2].area      = in_i.third_area;
    item_in.read_bin          = in_i.read_bin;
  end

  assign in_i.ready = (state_q == S_IDLE);
  assign in_accept  = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= item_in;
    end
  end

  // pick the strongest valid echo and its bin from the held item
  erbs_select u_select (
    .item_i (item_q),
    .cfg_i  (cfg_q),
    .pick_o (pick_comb)
  );

  always_ff @(posedge clk_i) begin
    if (state_q == S_SEL) begin
      pick_q <= pick_comb;
    end
    // squares are formed while the memory read is in flight
    if (state_q == S_RD) begin
      sq_area_q <= {{DATA_W{1'b0}}, pick_q.best.area} * {{DATA_W{1'b0}}, pick_q.best.area};
      sq_peak_q <= {{DATA_W{1'b0}}, pick_q.best.peak} * {{DATA_W{1'b0}}, pick_q.best.peak};
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (clr_cnt_q == BIN_W'(BIN_LAST)) state_d = S_IDLE;
      S_IDLE:  if (in_accept) state_d = S_SEL;
      S_SEL:   state_d = S_RD;
      S_RD:    state_d = S_MOD;
      S_MOD:   if (out_free) state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  always_comb begin
    clr_cnt_d = clr_cnt_q;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = pick_q.bin;
    out_load  = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        clr_cnt_d = clr_cnt_q + 1'b1;
      end
      S_RD: begin
        mem_re = 1'b1;
      end
      S_MOD: begin
        // hold the write back until the previous result has been taken
        out_load = out_free;
        mem_we   = out_free && pick_q.found;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // --------------------------------------------------------------------------
  // Saturating update; stored sums never exceed their top, so a carry out
  // of the stored width is the overflow test.
  // --------------------------------------------------------------------------
  always_comb begin
    logic [SUM_W:0]   s_dist;
    logic [SUM_W:0]   s_area;
    logic [SUM_W:0]   s_peak;
    logic [SQSUM_W:0] s_area_sq;
    logic [SQSUM_W:0] s_peak_sq;
    logic [CNT_W:0]   s_count;

    s_dist    = {1'b0, mem_rdata_q.distance} + (SUM_W+1)'(pick_q.best.distance);
    s_area    = {1'b0, mem_rdata_q.area} + (SUM_W+1)'(pick_q.best.area);
    s_peak    = {1'b0, mem_rdata_q.peak} + (SUM_W+1)'(pick_q.best.peak);
    s_area_sq = {1'b0, mem_rdata_q.area_sq} + (SQSUM_W+1)'(sq_area_q);
    s_peak_sq = {1'b0, mem_rdata_q.peak_sq} + (SQSUM_W+1)'(sq_peak_q);
    s_count   = {1'b0, mem_rdata_q.count} + (CNT_W+1)'(1);

    upd.distance = s_dist[SUM_W]      ? '1 : s_dist[SUM_W-1:0];
    upd.area     = s_area[SUM_W]      ? '1 : s_area[SUM_W-1:0];
    upd.peak     = s_peak[SUM_W]      ? '1 : s_peak[SUM_W-1:0];
    upd.area_sq  = s_area_sq[SQSUM_W] ? '1 : s_area_sq[SQSUM_W-1:0];
    upd.peak_sq  = s_peak_sq[SQSUM_W] ? '1 : s_peak_sq[SQSUM_W-1:0];
    upd.count    = s_count[CNT_W]     ? '1 : s_count[CNT_W-1:0];
  end

  assign mem_wdata = (state_q == S_CLEAR) ? '0 : upd;

  // Items run one at a time, so a write back always lands before the next
  // read of any bin: no forwarding path is needed.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      bin_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      mem_rdata_q <= bin_mem[pick_q.bin];
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_comb begin
    if (pick_q.found) begin
      out_d.counted     = 1'b1;
      out_d.bin_touched = RBIN_W'(pick_q.bin);
      out_d.totals      = upd;
    end else if (pick_q.rd_mode) begin
      out_d.counted     = 1'b0;
      out_d.bin_touched = RBIN_W'(pick_q.bin);
      out_d.totals      = mem_rdata_q;
    end else begin
      // skipped slot or no valid echo: all zero
      out_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.counted           = out_q.counted;
  assign out_o.bin_touched       = out_q.bin_touched;
  assign out_o.distance_total    = out_q.totals.distance;
  assign out_o.area_total        = out_q.totals.area;
  assign out_o.peak_total        = out_q.totals.peak;
  assign out_o.area_square_total = out_q.totals.area_sq;
  assign out_o.peak_square_total = out_q.totals.peak_sq;
  assign out_o.sample_count      = out_q.totals.count;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `ERBS_ASSERT_NOW(a_counted_nonzero, clk_i, rst_ni,
    out_valid_q && out_q.counted, (out_q.totals.count != '0) && (out_q.totals.distance != '0))
  `ERBS_ASSERT_NOW(a_bin_in_range, clk_i, rst_ni,
    out_valid_q, RBIN_W'(out_q.bin_touched) <= RBIN_W'(BIN_LAST))
  `ERBS_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni,
    in_accept, !in_i.ready && (state_q == S_SEL))

endmodule
